FILE: hdl/utf8fc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8fc_pkg
// Shared constants and types of the UTF-8 to font code layout block.
// ----------------------------------------------------------------------------
package utf8fc_pkg;

	localparam int CELL_WIDTH = 6;
	localparam int MAX_GLYPHS = 255;

	localparam int START_X_W = 12;
	localparam int SCALE_W   = 5;
	localparam int CFG_W     = 12;
	localparam int ADV_W     = $clog2(CELL_WIDTH * ((1 << SCALE_W) - 1) + 1);

	localparam logic [15:0] PEN_MAX   = 16'h7fff;
	localparam logic [14:0] WIDTH_MAX = 15'h7fff;

	// configuration register indexes
	localparam logic REG_START_X = 1'b0;
	localparam logic REG_SCALE   = 1'b1;

	// record kinds
	localparam logic KIND_GLYPH = 1'b0;
	localparam logic KIND_END   = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [6:0]         font_code;
		logic signed [15:0] glyph_x;
		logic [7:0]         glyph_index;
		logic [14:0]        total_width;
		logic               last;
	} result_t;

	typedef struct packed {
		logic [20:0]        accum;
		logic [1:0]         pending;
		logic [7:0]         count;
		logic signed [15:0] pen;
	} dec_state_t;

	// results produced by one byte, handed to the result queue
	typedef struct packed {
		logic [1:0] num;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

FILE: hdl/utf8fc_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8fc_decode
// Single-pass decode of one byte: next state and up to two result records.
// ----------------------------------------------------------------------------
module utf8fc_decode (
	input  logic [7:0]                        text_byte,
	input  utf8fc_pkg::dec_state_t            cur,
	input  logic signed [utf8fc_pkg::START_X_W-1:0] start_x,
	input  logic [utf8fc_pkg::SCALE_W-1:0]    scale,
	output utf8fc_pkg::dec_state_t            nxt,
	output utf8fc_pkg::push_t                 push
);
	import utf8fc_pkg::*;

	localparam logic [20:0] CP_LEFT  = 21'h025c0;
	localparam logic [20:0] CP_RIGHT = 21'h025b6;
	localparam logic [20:0] CP_DOT   = 21'h000b7;
	localparam logic [6:0]  FC_LEFT  = 7'h7f;
	localparam logic [6:0]  FC_RIGHT = 7'h7e;
	localparam logic [6:0]  FC_DOT   = 7'h2e;
	localparam logic [6:0]  FC_UNK   = 7'h3f;

	function automatic logic [6:0] map_code(input logic [20:0] cp);
		priority if (cp < 21'h80) return cp[6:0];
		else if (cp == CP_LEFT)   return FC_LEFT;
		else if (cp == CP_RIGHT)  return FC_RIGHT;
		else if (cp == CP_DOT)    return FC_DOT;
		else                      return FC_UNK;
	endfunction

	logic [ADV_W-1:0] adv;
	logic             pend;
	logic             cont;
	result_t          res [2];
	logic [1:0]       n;
	logic [16:0]      prod;
	logic signed [16:0] nx;

	assign adv  = ADV_W'(CELL_WIDTH) * ADV_W'(scale);
	assign pend = (cur.pending != 2'd0);
	assign cont = (text_byte[7:6] == 2'b10);

	always_comb begin
		nxt  = cur;
		n    = 2'd0;
		res[0] = '0;
		res[1] = '0;
		prod = '0;
		nx   = '0;

		if (pend && cont) begin
			nxt.accum   = {cur.accum[14:0], text_byte[5:0]};
			nxt.pending = cur.pending - 2'd1;
			if (nxt.pending == 2'd0) begin
				res[0] = '{KIND_GLYPH, map_code(nxt.accum), nxt.pen, nxt.count, 15'd0, 1'b0};
				nx = {nxt.pen[15], nxt.pen} + 17'(adv);
				nxt.pen = (nx[16:15] == 2'b01) ? signed'(PEN_MAX) : nx[15:0];
				if (nxt.count < 8'(MAX_GLYPHS)) nxt.count = nxt.count + 8'd1;
				nxt.accum = '0;
				n = 2'd1;
			end
		end else begin
			// flush a cut-short sequence as it stands
			if (pend) begin
				res[0] = '{KIND_GLYPH, map_code(cur.accum), nxt.pen, nxt.count, 15'd0, 1'b0};
				nx = {nxt.pen[15], nxt.pen} + 17'(adv);
				nxt.pen = (nx[16:15] == 2'b01) ? signed'(PEN_MAX) : nx[15:0];
				if (nxt.count < 8'(MAX_GLYPHS)) nxt.count = nxt.count + 8'd1;
				nxt.accum   = '0;
				nxt.pending = 2'd0;
				n = 2'd1;
			end

			priority if (text_byte == 8'h00) begin
				prod = 17'(nxt.count) * 17'(adv);
				res[n[0]] = '{KIND_END, 7'd0, 16'sd0, 8'd0,
					(prod > 17'(WIDTH_MAX)) ? WIDTH_MAX : prod[14:0], 1'b0};
				n = n + 2'd1;
				nxt.accum   = '0;
				nxt.pending = 2'd0;
				nxt.count   = '0;
				nxt.pen     = 16'(start_x);
			end else if (text_byte[7:4] == 4'hf) begin
				nxt.accum   = {18'd0, text_byte[2:0]};
				nxt.pending = 2'd3;
			end else if (text_byte[7:4] == 4'he) begin
				nxt.accum   = {17'd0, text_byte[3:0]};
				nxt.pending = 2'd2;
			end else if (text_byte[7:5] == 3'b110) begin
				nxt.accum   = {16'd0, text_byte[4:0]};
				nxt.pending = 2'd1;
			end else begin
				res[n[0]] = '{KIND_GLYPH, map_code({13'd0, text_byte}), nxt.pen, nxt.count,
					15'd0, 1'b0};
				nx = {nxt.pen[15], nxt.pen} + 17'(adv);
				nxt.pen = (nx[16:15] == 2'b01) ? signed'(PEN_MAX) : nx[15:0];
				if (nxt.count < 8'(MAX_GLYPHS)) nxt.count = nxt.count + 8'd1;
				n = n + 2'd1;
			end
		end

		if (n != 2'd0) res[n[0] ^ 1'b1].last = 1'b1;
	end

	assign push = '{num: n, r0: res[0], r1: res[1]};

endmodule

FILE: hdl/utf8fc_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8fc_result_fifo
// Four-entry result queue; takes up to two records per cycle, gives one while out_ready is high.
// ----------------------------------------------------------------------------
module utf8fc_result_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_en,
	input  utf8fc_pkg::push_t   push,
	output logic                room,
	output logic                out_valid,
	input  logic                out_ready,
	output utf8fc_pkg::result_t head
);
	import utf8fc_pkg::*;

	result_t    mem_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] cnt_q;
	logic [1:0] push_n;
	logic       pop;

	assign push_n    = push_en ? push.num : 2'd0;
	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != 3'd0);
	assign room      = (cnt_q <= 3'd2);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem_q[wr_ptr_q] <= push.r0;
		if (push_n == 2'd2) mem_q[wr_ptr_q + 2'd1] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n;
			rd_ptr_q <= rd_ptr_q + 2'(pop);
			cnt_q    <= cnt_q + 3'(push_n) - 3'(pop);
		end
	end

endmodule

FILE: hdl/utf8_to_font_code_layout.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_font_code_layout
// Decodes a UTF-8 byte stream into 7-bit font codes with x layout and an
// end-of-string record carrying the total width.
// ----------------------------------------------------------------------------
// Flow: a byte is registered in stage one, decoded once the result queue has
//   room, and its results are written to the queue, which offers them.
// Throughput: one byte per cycle while each byte gives at most one result and
//   out_ready stays high; a byte giving two results needs two output transfers.
// Reset: arst_n clears the decoder state, the queue, start_x to 0, scale to 1.
// ----------------------------------------------------------------------------
module utf8_to_font_code_layout (
	input  logic                clk,
	input  logic                arst_n,
	// byte channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          text_byte,
	// result channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic                kind,
	output logic [6:0]          font_code,
	output logic signed [15:0]  glyph_x,
	output logic [7:0]          glyph_index,
	output logic [14:0]         total_width,
	output logic                last,
	// configuration write port
	input  logic                cfg_wr_en,
	input  logic                cfg_index,
	input  logic [utf8fc_pkg::CFG_W-1:0] cfg_data
);
	import utf8fc_pkg::*;

	// configuration registers
	logic signed [START_X_W-1:0] start_x_q;
	logic [SCALE_W-1:0]          scale_q;

	// input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// decoder state
	dec_state_t state_q;
	dec_state_t state_nxt;
	push_t      push;

	logic    room;
	logic    fire;
	result_t head;

	// The byte in stage one is decoded once the queue can take two records;
	// that keeps the worst case (flush plus a new glyph or end record) safe.
	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) byte_s1 <= text_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	utf8fc_decode u_decode (
		.text_byte (byte_s1),
		.cur       (state_q),
		.start_x   (start_x_q),
		.scale     (scale_q),
		.nxt       (state_nxt),
		.push      (push)
	);

	// Configuration is to be written only while idle; the block does not enforce
	// it. Loading start_x also moves the pen while the string has no glyph yet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			scale_q   <= SCALE_W'(1);
			state_q   <= '0;
		end else begin
			if (fire) begin
				state_q <= state_nxt;
			end else if (cfg_wr_en && (cfg_index == REG_START_X)
			             && (state_q.count == 8'd0)) begin
				state_q.pen <= 16'(signed'(cfg_data[START_X_W-1:0]));
			end
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_START_X: start_x_q <= cfg_data[START_X_W-1:0];
					REG_SCALE:   scale_q   <= cfg_data[SCALE_W-1:0];
					default:     ;
				endcase
			end
		end
	end

	utf8fc_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (fire),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign kind        = head.kind;
	assign font_code   = head.font_code;
	assign glyph_x     = head.glyph_x;
	assign glyph_index = head.glyph_index;
	assign total_width = head.total_width;
	assign last        = head.last;

	// Two records from one byte only happen when a sequence is cut short.
	a_two_needs_open: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && push.num == 2'd2) |-> (state_q.pending != 2'd0))
		else $error("two results without an open sequence");

	// An end record is always the final record of its byte and carries no glyph.
	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_END) |->
		(last && font_code == 7'd0 && glyph_x == 16'sd0 && glyph_index == 8'd0))
		else $error("malformed end record");

	// A zero byte leaves the decoder ready for a fresh string.
	a_zero_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && byte_s1 == 8'h00) |=> (state_q.count == 8'd0 && state_q.pending == 2'd0))
		else $error("string state not cleared after zero byte");

	// Within a string the glyph count never goes down.
	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && byte_s1 != 8'h00) |=> (state_q.count >= $past(state_q.count)))
		else $error("glyph count went backwards");

endmodule
